// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ----- hdl/rndem_pkg.sv -----
// Package with pixel and result types, register indexes and constants.
package rndem_pkg;

	localparam int COORD_W = 12;
	localparam int BOUND_W = 10;

	localparam logic [COORD_W-1:0] ROW_MAX = 12'd4095;
	localparam logic [7:0] DEFAULT_THRESHOLD = 8'd20;
	localparam logic [12:0] DEFAULT_LINE_WIDTH = 13'd640;

	typedef enum logic {
		REG_THRESHOLD  = 1'b0,
		REG_LINE_WIDTH = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [4:0] pad;
		logic [COORD_W-1:0] pixel_column;
		logic [COORD_W-1:0] pixel_row;
		logic any_edge;
		logic vertical_edge;
		logic horizontal_edge;
	} result_t;

	// floor(sum / 3) > t  <=>  sum >= 3 * t + 3
	function automatic logic [BOUND_W-1:0] thr_bound(input logic [7:0] t);
		return BOUND_W'({t, 1'b0}) + BOUND_W'(t) + BOUND_W'(3);
	endfunction

endpackage

// ----- hdl/rndem_diff.sv -----
// Sum of absolute channel differences of two pixels against a bound.
module rndem_diff (
	input  rndem_pkg::pixel_t a,
	input  rndem_pkg::pixel_t b,
	input  logic [rndem_pkg::BOUND_W-1:0] bound,
	output logic flag
);
	import rndem_pkg::*;

	logic [7:0] d_r, d_g, d_b;
	logic [BOUND_W-1:0] sum;

	always_comb begin
		d_r = (a.red > b.red) ? a.red - b.red : b.red - a.red;
		d_g = (a.green > b.green) ? a.green - b.green : b.green - a.green;
		d_b = (a.blue > b.blue) ? a.blue - b.blue : b.blue - a.blue;
		sum = BOUND_W'(d_r) + BOUND_W'(d_g) + BOUND_W'(d_b);
		flag = (sum >= bound);
	end

endmodule

// ----- hdl/rgb_neighbour_difference_edge_marker_top.sv -----
// Top level: edge marker with line store, position counters and output register.
//
// channel  dir  fields (low bit first)
// s_*      in   tdata: blue, green, red; tuser: start_of_frame
// m_*      out  tdata: horizontal_edge, vertical_edge, any_edge, pixel_row, pixel_column
// cfg_*    in   index 0 threshold, index 1 line_width
//
// One pixel per clock unless the output stalls; a result is held in the first stage,
// then in the output register. The line store is read and written at the same edge
// (old data read), so no forwarding is needed. Reset needs no clearing pass; store
// contents are unknown until written. A stalled output holds both stages; s_tready
// falls once the first stage also holds a request.
module rgb_neighbour_difference_edge_marker_top #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [23:0] s_tdata,    // blue, green, red
	input  logic s_tuser,           // start_of_frame
	output logic m_tvalid,
	input  logic m_tready,
	output logic [31:0] m_tdata,    // horizontal_edge, vertical_edge, any_edge, pixel_row,
	                                // pixel_column, zero pad
	input  logic cfg_we,
	input  rndem_pkg::reg_idx_t cfg_index,
	input  logic [12:0] cfg_wdata
);
	import rndem_pkg::*;

	localparam int LIM = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
	localparam int AW = $clog2(LIM);
	localparam int RESET_W = (640 < LIM) ? 640 : LIM;

	logic [BOUND_W-1:0] thr_q;
	logic [COORD_W-1:0] wlast_q;
	logic [12:0] wl;

	logic [COORD_W-1:0] col_q, row_q, col_c, row_c, row_inc;
	pixel_t left_q, pix;
	logic accept, out_adv, s1_adv;

	logic s1_v_q, out_v_q;
	pixel_t pix_s1, left_s1, up_s1;
	logic [COORD_W-1:0] col_s1, row_s1;
	logic h_raw, v_raw, h_flag, v_flag;
	result_t out_q;

	pixel_t line_mem [LIM];

	assign pix = pixel_t'(s_tdata);

	always_comb begin
		priority if (cfg_wdata == '0)
			wl = '0;
		else if (cfg_wdata > 13'(LIM))
			wl = 13'(LIM - 1);
		else
			wl = cfg_wdata - 13'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= thr_bound(DEFAULT_THRESHOLD);
			wlast_q <= COORD_W'(RESET_W - 1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD:  thr_q <= thr_bound(cfg_wdata[7:0]);
				REG_LINE_WIDTH: wlast_q <= wl[COORD_W-1:0];
			endcase
		end
	end

	always_comb begin
		if (s_tuser) begin
			col_c = '0;
			row_c = '0;
		end else if (col_q > wlast_q) begin
			col_c = '0;
			row_c = (row_q == ROW_MAX) ? row_q : row_q + COORD_W'(1);
		end else begin
			col_c = col_q;
			row_c = row_q;
		end
		row_inc = (row_c == ROW_MAX) ? row_c : row_c + COORD_W'(1);
	end

	assign out_adv = !out_v_q || m_tready;
	assign s1_adv = s1_v_q && out_adv;
	assign s_tready = !s1_v_q || out_adv;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			left_q <= '0;
			s1_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_tready)
				s1_v_q <= s_tvalid;
			if (out_adv)
				out_v_q <= s1_v_q;
			if (accept) begin
				left_q <= pix;
				if (col_c >= wlast_q) begin
					col_q <= '0;
					row_q <= row_inc;
				end else begin
					col_q <= col_c + COORD_W'(1);
					row_q <= row_c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix;
			left_s1 <= left_q;
			col_s1 <= col_c;
			row_s1 <= row_c;
		end
	end

	// line store: read old entry, write new pixel at the same address
	always_ff @(posedge clk) begin
		if (accept) begin
			up_s1 <= line_mem[col_c[AW-1:0]];
			line_mem[col_c[AW-1:0]] <= pix;
		end
	end

	rndem_diff u_diff_h (
		.a     (pix_s1),
		.b     (left_s1),
		.bound (thr_q),
		.flag  (h_raw)
	);

	rndem_diff u_diff_v (
		.a     (pix_s1),
		.b     (up_s1),
		.bound (thr_q),
		.flag  (v_raw)
	);

	assign h_flag = h_raw && (col_s1 != '0);
	assign v_flag = v_raw && (row_s1 != '0);

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.pad <= '0;
			out_q.pixel_column <= col_s1;
			out_q.pixel_row <= row_s1;
			out_q.any_edge <= h_flag || v_flag;
			out_q.vertical_edge <= v_flag;
			out_q.horizontal_edge <= h_flag;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

endmodule

// ----- hdl/rndem_checker.sv -----
// Port-level checker for the edge marker and its bind statement.
`include "assert_macros.svh"

module rndem_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [31:0] m_tdata
);
	import rndem_pkg::*;

	result_t res;
	assign res = result_t'(m_tdata);

	`ASSERT_IMPLY(a_any_union, clk, arst_n, m_tvalid, res.any_edge == (res.horizontal_edge || res.vertical_edge), "any_edge is not the union of both marks")
	`ASSERT_IMPLY(a_col0_no_h, clk, arst_n, m_tvalid && (res.pixel_column == '0), !res.horizontal_edge, "horizontal mark in first column")
	`ASSERT_IMPLY(a_row0_no_v, clk, arst_n, m_tvalid && (res.pixel_row == '0), !res.vertical_edge, "vertical mark in first row")
	`ASSERT_CLK(a_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind rgb_neighbour_difference_edge_marker_top rndem_checker u_rndem_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- test/testbench.sv -----
// Self-checking testbench for the RGB neighbour-difference edge marker.
`timescale 1ns / 1ps

module testbench;
	import rndem_pkg::*;

	localparam int MAX_W = 4096;
	localparam int ROW_TOP = 4095;
	localparam int IDLE_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [23:0] s_tdata;    // blue, green, red
	logic s_tuser;           // start_of_frame
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;    // horizontal_edge, vertical_edge, any_edge, pixel_row,
	                         // pixel_column, zero pad
	logic cfg_we;
	reg_idx_t cfg_index;
	logic [12:0] cfg_wdata;

	// predictor state
	logic [7:0] thresh;
	logic [12:0] line_w;
	pixel_t left_px;
	pixel_t line_mem [MAX_W];
	bit line_valid [MAX_W];
	int col_cnt;
	int row_cnt;
	result_t pending_marks [$];

	int errors;
	int sent;
	int idle_cycles;
	int ready_hold;
	bit full_rate;

	rgb_neighbour_difference_edge_marker_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int eff_width();
		int w;
		w = line_w;
		if (w == 0)
			w = 1;
		if (w > MAX_W)
			w = MAX_W;
		return w;
	endfunction

	function automatic void pixel_position(input logic sof, output int row, output int col);
		if (sof) begin
			row = 0;
			col = 0;
		end else begin
			row = row_cnt;
			col = col_cnt;
			if (col >= eff_width()) begin
				col = 0;
				if (row < ROW_TOP)
					row++;
			end
		end
	endfunction

	function automatic logic exceeds(pixel_t a, pixel_t b);
		int sum;
		sum = (a.red > b.red ? a.red - b.red : b.red - a.red)
			+ (a.green > b.green ? a.green - b.green : b.green - a.green)
			+ (a.blue > b.blue ? a.blue - b.blue : b.blue - a.blue);
		return (sum / 3) > int'(thresh);
	endfunction

	// next pixel: fully random or close to a neighbour so the sum lands near the threshold
	function automatic pixel_t make_pixel();
		pixel_t base;
		pixel_t px;
		int row;
		int col;
		int d;
		int ch [3];
		pixel_position(1'b0, row, col);
		if ($urandom_range(0, 99) < 35)
			return pixel_t'(24'($urandom_range(0, 24'hFFFFFF)));
		base = left_px;
		if ($urandom_range(0, 1) && row > 0 && line_valid[col])
			base = line_mem[col];
		ch[0] = base.blue;
		ch[1] = base.green;
		ch[2] = base.red;
		for (int i = 0; i < 3; i++) begin
			d = $urandom_range(0, 2 * int'(thresh) + 4);
			ch[i] = $urandom_range(0, 1) ? ch[i] + d : ch[i] - d;
			if (ch[i] < 0)
				ch[i] = 0;
			if (ch[i] > 255)
				ch[i] = 255;
		end
		px.blue = 8'(ch[0]);
		px.green = 8'(ch[1]);
		px.red = 8'(ch[2]);
		return px;
	endfunction

	task automatic mark_pixel(input pixel_t px, input logic sof);
		int row;
		int col;
		int w;
		result_t r;
		w = eff_width();
		pixel_position(sof, row, col);
		r = '0;
		r.horizontal_edge = (col > 0) && exceeds(px, left_px);
		r.vertical_edge = (row > 0) && exceeds(px, line_mem[col]);
		r.any_edge = r.horizontal_edge | r.vertical_edge;
		r.pixel_row = row[11:0];
		r.pixel_column = col[11:0];
		line_mem[col] = px;
		line_valid[col] = 1'b1;
		left_px = px;
		if (col + 1 >= w) begin
			col_cnt = 0;
			row_cnt = row < ROW_TOP ? row + 1 : ROW_TOP;
		end else begin
			col_cnt = col + 1;
			row_cnt = row;
		end
		pending_marks.push_back(r);
	endtask

	task automatic send_pixel(input pixel_t px, input logic sof);
		int gap;
		int row;
		int col;
		pixel_position(sof, row, col);
		// never compare against a line entry that was never written
		if (row != 0 && !line_valid[col])
			sof = 1'b1;
		gap = full_rate ? 0 : pause_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		s_tuser <= sof;
		do @(posedge clk); while (!s_tready);
		mark_pixel(px, sof);
		sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_marks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [12:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_THRESHOLD)
			thresh = val[7:0];
		else
			line_w = val;
	endtask

	task automatic test_reset_defaults();
		send_pixel(pixel_t'({8'd0, 8'd0, 8'd0}), 1'b1);
		send_pixel(pixel_t'({8'd21, 8'd21, 8'd20}), 1'b0);
		send_pixel(pixel_t'({8'd42, 8'd42, 8'd42}), 1'b0);
		send_pixel(pixel_t'({8'd21, 8'd21, 8'd21}), 1'b0);
	endtask

	task automatic test_extremes();
		pixel_t pats [10] = '{
			pixel_t'({8'd0, 8'd0, 8'd0}), pixel_t'({8'd255, 8'd255, 8'd255}),
			pixel_t'({8'd255, 8'd0, 8'd0}), pixel_t'({8'd0, 8'd255, 8'd0}),
			pixel_t'({8'd0, 8'd0, 8'd255}), pixel_t'({8'd0, 8'd0, 8'd254}),
			pixel_t'({8'd0, 8'd1, 8'd255}), pixel_t'({8'd0, 8'd255, 8'd2}),
			pixel_t'({8'd170, 8'd85, 8'd255}), pixel_t'({8'd85, 8'd170, 8'd0})
		};
		wait_idle();
		write_reg(REG_THRESHOLD, 13'd0);
		write_reg(REG_LINE_WIDTH, 13'd4);
		for (int i = 0; i < 10; i++)
			send_pixel(pats[i], i == 0);
		wait_idle();
		write_reg(REG_THRESHOLD, 13'd255);
		for (int i = 0; i < 6; i++)
			send_pixel(i[0] ? pixel_t'(24'hFFFFFF) : pixel_t'(24'h000000), i == 0);
	endtask

	task automatic test_width_shrink();
		wait_idle();
		write_reg(REG_THRESHOLD, 13'd30);
		write_reg(REG_LINE_WIDTH, 13'd8);
		send_pixel(make_pixel(), 1'b1);
		repeat (5) send_pixel(make_pixel(), 1'b0);
		wait_idle();
		write_reg(REG_LINE_WIDTH, 13'd3);
		repeat (6) send_pixel(make_pixel(), 1'b0);
		wait_idle();
		write_reg(REG_LINE_WIDTH, 13'd0);
		repeat (4) send_pixel(make_pixel(), 1'b0);
	endtask

	task automatic test_single_column();
		wait_idle();
		write_reg(REG_THRESHOLD, 13'd40);
		write_reg(REG_LINE_WIDTH, 13'd1);
		send_pixel(make_pixel(), 1'b1);
		repeat (60) send_pixel(make_pixel(), 1'b0);
	endtask

	task automatic test_wide_rows();
		wait_idle();
		write_reg(REG_THRESHOLD, 13'($urandom_range(0, 50)));
		write_reg(REG_LINE_WIDTH, 13'd8191);
		send_pixel(make_pixel(), 1'b1);
		repeat (100) send_pixel(make_pixel(), 1'b0);
	endtask

	task automatic test_random_frames();
		int stop_at;
		int n;
		int r;
		stop_at = sent + 1400;
		while (sent < stop_at) begin
			wait_idle();
			r = $urandom_range(0, 99);
			if (r < 10)
				write_reg(REG_THRESHOLD, 13'd0);
			else if (r < 20)
				write_reg(REG_THRESHOLD, 13'd255);
			else if (r < 40)
				write_reg(REG_THRESHOLD, 13'($urandom_range(0, 255)));
			else if (r < 90)
				write_reg(REG_THRESHOLD, 13'($urandom_range(0, 40)));
			r = $urandom_range(0, 99);
			if (r < 50)
				write_reg(REG_LINE_WIDTH, 13'($urandom_range(1, 16)));
			else if (r < 65)
				write_reg(REG_LINE_WIDTH, 13'($urandom_range(17, 64)));
			else if (r < 75)
				write_reg(REG_LINE_WIDTH, 13'd640);
			else if (r < 80)
				write_reg(REG_LINE_WIDTH, 13'd4096);
			else if (r < 85)
				write_reg(REG_LINE_WIDTH, 13'd0);
			else if (r < 90)
				write_reg(REG_LINE_WIDTH, 13'($urandom_range(4097, 8191)));
			full_rate = ($urandom_range(0, 3) == 0);
			n = $urandom_range(10, 80);
			for (int i = 0; i < n; i++)
				send_pixel(make_pixel(),
					(i == 0 && $urandom_range(0, 1)) || $urandom_range(0, 49) == 0);
			full_rate = 1'b0;
		end
	endtask

	// downstream stalls
	always @(posedge clk) begin
		if (full_rate) begin
			m_tready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			ready_hold <= pause_len();
		end else begin
			m_tready <= 1'b1;
			ready_hold <= $urandom_range(0, 15);
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata);
			if (pending_marks.size() == 0) begin
				$error("result with no request pending: %h", m_tdata);
				errors++;
			end else begin
				want = pending_marks.pop_front();
				if (got.horizontal_edge !== want.horizontal_edge) begin
					$error("horizontal_edge: expected %0d, got %0d",
						want.horizontal_edge, got.horizontal_edge);
					errors++;
				end
				if (got.vertical_edge !== want.vertical_edge) begin
					$error("vertical_edge: expected %0d, got %0d",
						want.vertical_edge, got.vertical_edge);
					errors++;
				end
				if (got.any_edge !== want.any_edge) begin
					$error("any_edge: expected %0d, got %0d", want.any_edge, got.any_edge);
					errors++;
				end
				if (got.pixel_row !== want.pixel_row) begin
					$error("pixel_row: expected %0d, got %0d", want.pixel_row, got.pixel_row);
					errors++;
				end
				if (got.pixel_column !== want.pixel_column) begin
					$error("pixel_column: expected %0d, got %0d",
						want.pixel_column, got.pixel_column);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		m_tready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_THRESHOLD;
		cfg_wdata <= '0;
		ready_hold = 0;
		idle_cycles = 0;
		full_rate = 1'b0;
		errors = 0;
		sent = 0;
		thresh = DEFAULT_THRESHOLD;
		line_w = DEFAULT_LINE_WIDTH;
		left_px = '0;
		col_cnt = 0;
		row_cnt = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_extremes();
		test_width_shrink();
		test_random_frames();
		test_single_column();
		test_wide_rows();

		wait_idle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
